@@ src/psmrl_pkg.sv @@
// Shared types, constants and message type tables of the per-source rate limiter.
`default_nettype none

package psmrl_pkg;

  localparam int NUM_SOURCES_DEF = 256;
  localparam int NUM_CLASSES_DEF = 11;
  localparam int TIME_BITS_DEF   = 48;

  localparam int TYPE_W   = 18;
  localparam int SRC_IN_W = 8;
  localparam int NOW_W    = 48;
  localparam int IVL_W    = 16;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;
  localparam int CLS_IDX_W = 4;
  localparam int NUM_TYPES = 11;
  localparam int NUM_SRC_CODES = 256;

  localparam logic [IVL_W-1:0] MIN_INTERVAL_RST = 16'd1000;

  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_ENABLE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 8'd1;

  localparam logic [TYPE_W-1:0] RATE_TYPES [NUM_TYPES] = '{
    18'd127250, 18'd130306, 18'd128267, 18'd128259, 18'd127245, 18'd129026,
    18'd129539, 18'd129029, 18'd130311, 18'd128275, 18'd126992
  };

  localparam logic [TYPE_W-1:0] AIS_TYPES [NUM_TYPES] = '{
    18'd129038, 18'd129039, 18'd129040, 18'd129041, 18'd129793, 18'd129794,
    18'd129798, 18'd129801, 18'd129802, 18'd129809, 18'd129810
  };

  typedef enum logic [1:0] {
    KIND_UNKNOWN = 2'd0,
    KIND_PASS    = 2'd1,
    KIND_RATED   = 2'd2
  } class_kind_t;

  typedef enum logic [1:0] {
    VERDICT_UNKNOWN = 2'd0,
    VERDICT_LIMITED = 2'd1,
    VERDICT_PASSED  = 2'd2
  } verdict_t;

  typedef struct packed {
    class_kind_t            kind;
    logic [CLS_IDX_W-1:0]   cls_idx;
  } class_info_t;

  typedef struct packed {
    logic             limit_enable;
    logic [IVL_W-1:0] min_interval_ms;
  } cfg_t;

endpackage

`default_nettype wire

@@ src/psmrl_cfg_regs.sv @@
// Configuration register file: limit enable and minimum interval.
`default_nettype none

module psmrl_cfg_regs
  import psmrl_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata,
  output cfg_t                      cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_LIMIT_ENABLE: cfg_nxt.limit_enable = cfg_wdata[0];
        REG_MIN_INTERVAL: cfg_nxt.min_interval_ms = cfg_wdata[IVL_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.limit_enable    <= 1'b0;
      cfg_r.min_interval_ms <= MIN_INTERVAL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/psmrl_classify.sv @@
// Message type decoder and source address to slot row mapping.
`default_nettype none

module psmrl_classify
  import psmrl_pkg::*;
#(
  parameter int NUM_SOURCES = NUM_SOURCES_DEF,
  parameter int NUM_CLASSES = NUM_CLASSES_DEF,
  localparam int SRC_W = $clog2(NUM_SOURCES)
) (
  input  wire logic [TYPE_W-1:0]   msg_type,
  input  wire logic [SRC_IN_W-1:0] source_addr,
  output class_info_t              info,
  output logic [SRC_W-1:0]         row
);

  logic [SRC_W-1:0] row_tbl [NUM_SRC_CODES];
  logic             rate_hit;
  logic             ais_hit;
  logic [CLS_IDX_W-1:0] rate_idx;

  for (genvar g = 0; g < NUM_SRC_CODES; g++) begin : g_row
    assign row_tbl[g] = SRC_W'(g % NUM_SOURCES);
  end

  assign row = row_tbl[source_addr];

  always_comb begin
    rate_hit = 1'b0;
    ais_hit  = 1'b0;
    rate_idx = '0;
    for (int i = 0; i < NUM_TYPES; i++) begin
      if (RATE_TYPES[i] == msg_type) begin
        rate_hit = 1'b1;
        rate_idx = CLS_IDX_W'(i);
      end
      if (AIS_TYPES[i] == msg_type) begin
        ais_hit = 1'b1;
      end
    end
  end

  always_comb begin
    info.cls_idx = rate_idx;
    if (rate_hit) begin
      // A rate class without a slot in the table always passes.
      info.kind = (32'(rate_idx) < NUM_CLASSES) ? KIND_RATED : KIND_PASS;
    end else if (ais_hit) begin
      info.kind = KIND_PASS;
    end else begin
      info.kind = KIND_UNKNOWN;
    end
  end

endmodule

`default_nettype wire

@@ src/psmrl_slot_ram.sv @@
// Single-port-write, single-port-read slot memory with registered read data.
`default_nettype none

module psmrl_slot_ram #(
  parameter int DATA_W = 48,
  parameter int DEPTH  = 4096,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  assign rd_data = rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ src/per_source_message_rate_limiter.sv @@
// Top level of the per-source message rate limiter.
//
//   Port group | Dir | Words carried
//   in_        | in  | msg_type, source_addr, now_ms
//   out_       | out | verdict, one per input word
//   cfg_       | in  | index and data of a register write
//
// Sustained rate is one word per cycle while out_ready is high; out_valid rises when a
// word leaves stage one. Slot memory is read at acceptance and written as the word leaves
// stage one, and a one-entry forwarding register covers a back-to-back hit on the same slot.
// After reset a clearing pass zeroes the memory, one entry per cycle, over all
// NUM_SOURCES * 2^ceil(log2(NUM_CLASSES)) entries (4096 by default); in_ready stays low.
// A stalled output holds the pipeline stage behind it and lowers in_ready.
`default_nettype none

module per_source_message_rate_limiter
  import psmrl_pkg::*;
#(
  parameter int NUM_SOURCES = NUM_SOURCES_DEF,
  parameter int NUM_CLASSES = NUM_CLASSES_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [TYPE_W-1:0]    in_msg_type,
  input  wire logic [SRC_IN_W-1:0]  in_source_addr,
  input  wire logic [NOW_W-1:0]     in_now_ms,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [1:0]                out_verdict,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata
);

  localparam int SRC_W  = $clog2(NUM_SOURCES);
  localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int ADDR_W = SRC_W + CLS_W;
  localparam int DEPTH  = NUM_SOURCES * (2 ** CLS_W);

  cfg_t              cfg;
  class_info_t       info;
  logic [SRC_W-1:0]  row;
  logic [TIME_BITS-1:0] now_t;

  logic              clr_busy_r;
  logic [ADDR_W-1:0] clr_addr_r;

  logic                 s1_valid_r;
  class_kind_t          s1_kind_r;
  logic [ADDR_W-1:0]    s1_addr_r;
  logic [TIME_BITS-1:0] s1_now_r;

  logic                 fwd_valid_r;
  logic [ADDR_W-1:0]    fwd_addr_r;
  logic [TIME_BITS-1:0] fwd_data_r;

  logic     out_valid_r;
  verdict_t out_verdict_r;
  verdict_t verdict_nxt;

  logic                 in_acc;
  logic                 s1_adv;
  logic [ADDR_W-1:0]    rd_addr;
  logic [TIME_BITS-1:0] rd_data;
  logic [TIME_BITS-1:0] last_time;
  logic [TIME_BITS:0]   due_time;
  logic                 too_soon;
  logic                 upd;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [TIME_BITS-1:0] wr_data;

  psmrl_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  psmrl_classify #(
    .NUM_SOURCES (NUM_SOURCES),
    .NUM_CLASSES (NUM_CLASSES)
  ) u_classify (
    .msg_type    (in_msg_type),
    .source_addr (in_source_addr),
    .info        (info),
    .row         (row)
  );

  psmrl_slot_ram #(
    .DATA_W (TIME_BITS),
    .DEPTH  (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_acc),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  if (TIME_BITS <= NOW_W) begin : g_now_trunc
    assign now_t = in_now_ms[TIME_BITS-1:0];
  end else begin : g_now_ext
    assign now_t = {{(TIME_BITS-NOW_W){1'b0}}, in_now_ms};
  end

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !clr_busy_r && (!s1_valid_r || s1_adv);
  assign in_acc   = in_valid && in_ready;
  assign rd_addr  = {row, info.cls_idx[CLS_W-1:0]};

  assign last_time = (fwd_valid_r && (fwd_addr_r == s1_addr_r)) ? fwd_data_r : rd_data;
  assign due_time  = {1'b0, last_time} + {{(TIME_BITS+1-IVL_W){1'b0}}, cfg.min_interval_ms};
  assign too_soon  = due_time > {1'b0, s1_now_r};

  always_comb begin
    unique case (s1_kind_r)
      KIND_UNKNOWN: verdict_nxt = VERDICT_UNKNOWN;
      KIND_PASS:    verdict_nxt = VERDICT_PASSED;
      KIND_RATED:   verdict_nxt = (cfg.limit_enable && too_soon) ? VERDICT_LIMITED
                                                                 : VERDICT_PASSED;
      default:      verdict_nxt = VERDICT_UNKNOWN;
    endcase
  end

  assign upd     = s1_adv && (s1_kind_r == KIND_RATED) && cfg.limit_enable && !too_soon;
  assign wr_en   = clr_busy_r || upd;
  assign wr_addr = clr_busy_r ? clr_addr_r : s1_addr_r;
  assign wr_data = clr_busy_r ? '0 : s1_now_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r <= info.kind;
      s1_addr_r <= rd_addr;
      s1_now_r  <= now_t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr_busy_r) begin
      fwd_valid_r <= 1'b0;
    end else if (upd) begin
      fwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= s1_now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_verdict_r <= verdict_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

  a_no_accept_while_clearing: assert property (
    @(posedge clk) disable iff (!rst_n) clr_busy_r |-> !in_ready
  ) else $error("input accepted during the clearing pass");

  a_write_only_on_pass: assert property (
    @(posedge clk) disable iff (!rst_n)
      (wr_en && !clr_busy_r) |-> (s1_adv && (s1_kind_r == KIND_RATED) && cfg.limit_enable)
  ) else $error("slot written by a word that did not pass a rated check");

  a_adv_fills_output: assert property (
    @(posedge clk) disable iff (!rst_n) s1_adv |=> out_valid_r
  ) else $error("advanced word did not reach the output register");

  a_fwd_cleared_by_sweep: assert property (
    @(posedge clk) disable iff (!rst_n) clr_busy_r |=> !fwd_valid_r
  ) else $error("forwarding entry survived the clearing pass");

  a_s1_no_overrun: assert property (
    @(posedge clk) disable iff (!rst_n) (s1_valid_r && !s1_adv) |-> !in_acc
  ) else $error("stage one overwritten while stalled");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench of the per-source message rate limiter.
`default_nettype none

module tb_top;
  import psmrl_pkg::*;

  localparam int RESET_CYCLES = 6;
  localparam int NUM_PHASES = 8;
  localparam int WORDS_PER_PHASE = 80;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS = 10;
  localparam longint TIMEOUT = 64'd12_000_000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = REG_MIN_INTERVAL + 8'd1;
  localparam logic [NOW_W-1:0] TIME_ALL_ONES = '1;

  class verdict_scoreboard;
    logic [NOW_W-1:0] last_pass [NUM_SOURCES_DEF][NUM_CLASSES_DEF];
    logic limit_on;
    logic [IVL_W-1:0] interval;
    verdict_t expected_q[$];
    int mismatches;

    function new();
      foreach (last_pass[i, j]) last_pass[i][j] = '0;
      limit_on = 1'b0;
      interval = 16'd1000;
      mismatches = 0;
    endfunction

    function int rate_slot(input logic [TYPE_W-1:0] t);
      case (t)
        18'd127250: return 0;
        18'd130306: return 1;
        18'd128267: return 2;
        18'd128259: return 3;
        18'd127245: return 4;
        18'd129026: return 5;
        18'd129539: return 6;
        18'd129029: return 7;
        18'd130311: return 8;
        18'd128275: return 9;
        18'd126992: return 10;
        default: return -1;
      endcase
    endfunction

    function bit is_ais(input logic [TYPE_W-1:0] t);
      case (t)
        18'd129038, 18'd129039, 18'd129040, 18'd129041, 18'd129793, 18'd129794,
        18'd129798, 18'd129801, 18'd129802, 18'd129809, 18'd129810: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DAT_W-1:0] data);
      if (idx == REG_LIMIT_ENABLE) begin
        limit_on = data[0];
      end else if (idx == REG_MIN_INTERVAL) begin
        interval = data[IVL_W-1:0];
      end
    endfunction

    function void note_message(input logic [TYPE_W-1:0] mtype,
                               input logic [SRC_IN_W-1:0] src,
                               input logic [NOW_W-1:0] now);
      int slot;
      logic [NOW_W:0] earliest;
      slot = rate_slot(mtype);
      if (slot < 0) begin
        if (is_ais(mtype)) begin
          expected_q.push_back(VERDICT_PASSED);
        end else begin
          expected_q.push_back(VERDICT_UNKNOWN);
        end
      end else if (!limit_on) begin
        expected_q.push_back(VERDICT_PASSED);
      end else begin
        earliest = {1'b0, last_pass[src][slot]} + interval;
        if (earliest > {1'b0, now}) begin
          expected_q.push_back(VERDICT_LIMITED);
        end else begin
          last_pass[src][slot] = now;
          expected_q.push_back(VERDICT_PASSED);
        end
      end
    endfunction

    function void check_verdict(input logic [1:0] got);
      verdict_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("verdict %0d arrived with none expected", got);
        end
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("verdict mismatch: expected %0d, got %0d", want, got);
          end
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [TYPE_W-1:0] in_msg_type = '0;
  logic [SRC_IN_W-1:0] in_source_addr = '0;
  logic [NOW_W-1:0] in_now_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_verdict;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  logic [NOW_W-1:0] now_clock = '0;
  verdict_scoreboard sb;

  per_source_message_rate_limiter dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_msg_type(in_msg_type),
    .in_source_addr(in_source_addr),
    .in_now_ms(in_now_ms),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_verdict(out_verdict),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      sb.apply_register(cfg_index, cfg_wdata);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      sb.note_message(in_msg_type, in_source_addr, in_now_ms);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_verdict(out_verdict);
    end
  end

  task automatic send_message(input logic [TYPE_W-1:0] mtype,
                              input logic [SRC_IN_W-1:0] src,
                              input logic [NOW_W-1:0] now);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_msg_type <= mtype;
    in_source_addr <= src;
    in_now_ms <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input logic enable, input logic [IVL_W-1:0] ivl);
    write_reg(REG_LIMIT_ENABLE, {15'($urandom_range(0, 32767)), enable});
    write_reg(REG_MIN_INTERVAL, ivl);
    if ($urandom_range(0, 1) == 1) begin
      write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED, 255)), 16'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_random_message(input int ivl);
    logic [TYPE_W-1:0] mtype;
    logic [TYPE_W-1:0] near;
    logic [SRC_IN_W-1:0] src;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      mtype = RATE_TYPES[$urandom_range(0, 2)];
    end else if (pick < 55) begin
      mtype = RATE_TYPES[$urandom_range(0, NUM_TYPES - 1)];
    end else if (pick < 75) begin
      mtype = AIS_TYPES[$urandom_range(0, NUM_TYPES - 1)];
    end else if (pick < 87) begin
      near = RATE_TYPES[$urandom_range(0, NUM_TYPES - 1)];
      mtype = ($urandom_range(0, 1) == 1) ? near + 1'b1 : near - 1'b1;
    end else begin
      mtype = TYPE_W'($urandom_range(0, (1 << TYPE_W) - 1));
    end
    if ($urandom_range(0, 99) < 70) begin
      src = SRC_IN_W'($urandom_range(0, 3));
    end else begin
      src = SRC_IN_W'($urandom_range(0, 255));
    end
    now_clock = now_clock + NOW_W'($urandom_range(0, ivl / 8 + 1));
    send_message(mtype, src, now_clock);
  endtask

  initial begin
    #(TIMEOUT);
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic en;
    int ivl;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset configuration: limiting is off, so no slot changes.
    send_message('0, '0, '0);
    send_message('1, '1, TIME_ALL_ONES);
    send_message(18'd129038, 8'd255, TIME_ALL_ONES);
    send_message(18'd127250, 8'd255, TIME_ALL_ONES);
    wait_idle();

    // Interval reaching before time zero, then the exact boundary.
    configure(1'b1, 16'd1000);
    send_message(18'd126992, 8'd0, 48'd0);
    send_message(18'd126992, 8'd0, 48'd999);
    send_message(18'd126992, 8'd0, 48'd1000);
    send_message(18'd126992, 8'd0, 48'd1999);
    send_message(18'd126992, 8'd0, 48'd2000);
    send_message(18'd129810, 8'd0, 48'd2000);
    send_message(18'd130311, 8'd1, 48'd2000);
    send_message(18'd130311, 8'd1, 48'd2000);
    wait_idle();

    configure(1'b1, 16'd0);
    send_message(18'd130311, 8'd1, 48'd2000);
    send_message(18'd130311, 8'd1, 48'd2000);
    wait_idle();

    configure(1'b1, 16'hFFFF);
    send_message(18'd130311, 8'd1, 48'd67534);
    send_message(18'd130311, 8'd1, 48'd67535);
    wait_idle();

    // Only bit 0 of the enable word counts, and an unknown index is ignored.
    write_reg(REG_LIMIT_ENABLE, 16'hFFFE);
    write_reg(REG_UNUSED, 16'h0001);
    cfg_valid <= 1'b0;
    send_message(18'd130311, 8'd1, 48'd67535);
    send_message(18'd127251, 8'd1, 48'd67535);
    wait_idle();

    now_clock = 48'd70000;
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin en = 1'b1; ivl = 1000; end
        1: begin en = 1'b1; ivl = 1000; end
        2: begin en = 1'b1; ivl = 0; end
        3: begin en = 1'b0; ivl = $urandom_range(0, 65535); end
        4: begin en = 1'b1; ivl = 65535; end
        5: begin en = 1'b1; ivl = $urandom_range(1, 60); end
        6: begin en = 1'b1; ivl = $urandom_range(100, 5000); end
        default: begin en = 1'b1; ivl = 1000; end
      endcase
      send_idle_pct = (p % 4 == 1) ? 69 : (p % 4 == 3) ? 38 : 0;
      stall_pct = (p % 4 == 2) ? 69 : (p % 4 == 3) ? 38 : 0;
      if (p == 5) begin
        now_clock = now_clock + NOW_W'({$urandom_range(0, 32767), $urandom});
      end
      configure(en, IVL_W'(ivl));
      repeat (WORDS_PER_PHASE) send_random_message(ivl);
      wait_idle();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
